// File: sv/mfsgd_pkg.sv
// shared types, constants and helpers for the biased matrix factorization block
// no dependencies
package mfsgd_pkg;

    localparam int MAX_USERS  = 4096;
    localparam int MAX_MOVIES = 4096;
    localparam int FEATURES   = 32;

    localparam int USER_W  = $clog2(MAX_USERS);
    localparam int MOVIE_W = $clog2(MAX_MOVIES);
    localparam int FEAT_W  = $clog2(FEATURES);
    localparam int UF_AW   = USER_W + FEAT_W;
    localparam int MF_AW   = MOVIE_W + FEAT_W;
    localparam int CLR_W   = (UF_AW > MF_AW) ? UF_AW : MF_AW;

    localparam int Q_W   = 24;
    localparam int SAT_W = 68;

    localparam logic signed [Q_W-1:0] Q_MAX       = 24'sh7fffff;
    localparam logic signed [Q_W-1:0] Q_MIN       = -24'sh800000;
    localparam logic signed [Q_W-1:0] FACTOR_INIT = 24'sd13107;

    localparam logic [2:0] CFG_GLOBAL_MEAN  = 3'd0;
    localparam logic [2:0] CFG_BIAS_STEP    = 3'd1;
    localparam logic [2:0] CFG_BIAS_DECAY   = 3'd2;
    localparam logic [2:0] CFG_FACTOR_STEP  = 3'd3;
    localparam logic [2:0] CFG_FACTOR_DECAY = 3'd4;
    localparam logic [2:0] CFG_FEATURES     = 3'd5;

    localparam logic [1:0] OP_TRAIN      = 2'd0;
    localparam logic [1:0] OP_PREDICT    = 2'd1;
    localparam logic [1:0] OP_LOAD_USER  = 2'd2;
    localparam logic [1:0] OP_LOAD_MOVIE = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [11:0]             user_index;
        logic [11:0]             movie_index;
        logic [3:0]              rating;
        logic signed [Q_W-1:0]   load_value;
    } t_item;

    typedef struct packed {
        logic signed [Q_W-1:0] prediction;
        logic signed [Q_W-1:0] error;
    } t_result;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < SAT_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/matrix_factorization_sgd.sv
// top level: bias and factor memories with the train / predict / load sequencer
// depends on mfsgd_pkg
//
// One item at a time. N is the number of features in use, at most 32. Every
// item first reads the factor memories one feature per cycle for the dot
// product. Prediction and error follow in S_PRED and S_ERR, and for a train
// item the bias updates in S_BTERM, S_BPROD and S_BWRITE. A pipelined
// read-modify-write pass then updates both factor rows, and the result follows
// in S_DONE. Predict and load items skip the bias and factor updates. Busy is
// low between items. After reset the block stays busy while it sweeps the reset
// values into the memories; configuration writes are taken at all times. The
// result is shown for one cycle on o_result with o_valid and cannot be held
// off.
module matrix_factorization_sgd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mfsgd_pkg::t_item     i_item,
    output logic                 o_valid,
    output mfsgd_pkg::t_result   o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [18:0]          i_cfg_data
);
    import mfsgd_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DOT    = 10'b0000000100,
        S_PRED   = 10'b0000001000,
        S_ERR    = 10'b0000010000,
        S_BTERM  = 10'b0000100000,
        S_BPROD  = 10'b0001000000,
        S_BWRITE = 10'b0010000000,
        S_UPD    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    t_item r_item;

    logic [18:0] r_gmean;
    logic [15:0] r_bstep, r_bdecay, r_fstep, r_fdecay;
    logic [5:0]  r_feat;
    logic [FEAT_W:0] r_n, r_issue;

    logic signed [Q_W-1:0] r_uf_mem [2**UF_AW];
    logic signed [Q_W-1:0] r_mf_mem [2**MF_AW];
    logic signed [Q_W-1:0] r_ub_mem [2**USER_W];
    logic signed [Q_W-1:0] r_mb_mem [2**MOVIE_W];
    logic signed [Q_W-1:0] r_p_q, r_q_q, r_ub_q, r_mb_q;

    logic r_rd_v, r_prod_v;
    logic signed [47:0] r_prod;
    logic signed [52:0] r_acc;

    logic signed [Q_W-1:0] r_pred, r_err;
    logic signed [41:0] r_tu, r_tm;
    logic signed [58:0] r_su, r_sm;

    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg;
    logic [FEAT_W-1:0] r_fa, r_fb, r_fc, r_fd, r_fe, r_ff, r_fg;
    logic signed [47:0] r_a_ep, r_e_eq;
    logic signed [40:0] r_a_dq, r_e_dp;
    logic signed [48:0] r_b_t, r_f_t;
    logic signed [65:0] r_c_s, r_g_s;
    logic signed [Q_W-1:0] r_a_p, r_a_q, r_b_p, r_b_q, r_c_p, r_c_q, r_d_p, r_d_q;
    logic signed [Q_W-1:0] r_e_p, r_e_q, r_f_p, r_f_q, r_g_p, r_g_q;

    logic issue, clr_last;
    logic signed [52:0] acc_rnd;
    logic signed [39:0] pred_sum;
    logic signed [26:0] err_sum;
    logic signed [40:0] du, dm;
    logic signed [58:0] su_rnd, sm_rnd;
    logic signed [65:0] c_rnd, g_rnd;
    logic signed [Q_W-1:0] q_new, p_new;
    logic f_we, ub_we, mb_we;
    logic [UF_AW-1:0] uf_wa, uf_ra;
    logic [MF_AW-1:0] mf_wa, mf_ra;
    logic [USER_W-1:0] ub_wa;
    logic [MOVIE_W-1:0] mb_wa;
    logic signed [Q_W-1:0] uf_wd, mf_wd, ub_wd, mb_wd;

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_cfg_ready = 1'b1;
    assign o_result.prediction = r_pred;
    assign o_result.error      = r_err;

    assign issue    = (r_issue < r_n) && (r_state == S_DOT || r_state == S_UPD);
    assign clr_last = (r_clr == {CLR_W{1'b1}});

    assign acc_rnd  = (r_acc + 53'sd32768) >>> 16;
    assign pred_sum = $signed({21'b0, r_gmean}) + 40'(r_ub_q) + 40'(r_mb_q) + 40'(acc_rnd);
    assign err_sum  = $signed({7'b0, r_item.rating, 16'b0}) - 27'(r_pred);
    assign du       = $signed({1'b0, r_bdecay}) * r_ub_q;
    assign dm       = $signed({1'b0, r_bdecay}) * r_mb_q;
    assign su_rnd   = (r_su + 59'sd2147483648) >>> 32;
    assign sm_rnd   = (r_sm + 59'sd2147483648) >>> 32;
    assign c_rnd    = (r_c_s + 66'sd2147483648) >>> 32;
    assign g_rnd    = (r_g_s + 66'sd2147483648) >>> 32;
    assign q_new    = sat_q(SAT_W'(c_rnd) + SAT_W'(r_c_q));
    assign p_new    = sat_q(SAT_W'(g_rnd) + SAT_W'(r_g_p));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (clr_last) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_DOT;
            S_DOT:    if (!issue && !r_rd_v && !r_prod_v) n_state = S_PRED;
            S_PRED:   n_state = S_ERR;
            S_ERR:    n_state = (r_item.opcode == OP_TRAIN) ? S_BTERM : S_DONE;
            S_BTERM:  n_state = S_BPROD;
            S_BPROD:  n_state = S_BWRITE;
            S_BWRITE: n_state = S_UPD;
            S_UPD: begin
                if (!issue && !r_rd_v && !r_va && !r_vb && !r_vc && !r_vd
                    && !r_ve && !r_vf && !r_vg) n_state = S_DONE;
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_issue  <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            {r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg} <= '0;
            r_gmean  <= 19'd196608;
            r_bstep  <= 16'd328;
            r_bdecay <= 16'd1311;
            r_fstep  <= 16'd328;
            r_fdecay <= 16'd1311;
            r_feat   <= 6'd32;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_IDLE || r_state == S_BWRITE) begin
                r_issue <= '0;
            end else if (issue) begin
                r_issue <= r_issue + 1'b1;
            end
            r_rd_v   <= issue;
            r_prod_v <= r_rd_v && (r_state == S_DOT);
            r_va <= r_rd_v && (r_state == S_UPD);
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_vg <= r_vf;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GLOBAL_MEAN:  r_gmean  <= i_cfg_data;
                    CFG_BIAS_STEP:    r_bstep  <= i_cfg_data[15:0];
                    CFG_BIAS_DECAY:   r_bdecay <= i_cfg_data[15:0];
                    CFG_FACTOR_STEP:  r_fstep  <= i_cfg_data[15:0];
                    CFG_FACTOR_DECAY: r_fdecay <= i_cfg_data[15:0];
                    CFG_FEATURES:     r_feat   <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_item <= i_item;
            r_n    <= (r_feat > 6'(FEATURES)) ? (FEAT_W+1)'(FEATURES) : r_feat[FEAT_W:0];
        end
        r_prod <= r_p_q * r_q_q;
        if (r_state == S_IDLE) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + 53'(r_prod);
        end
        if (r_state == S_PRED) r_pred <= sat_q(SAT_W'(pred_sum));
        if (r_state == S_ERR) begin
            r_err <= (r_item.opcode == OP_TRAIN) ? sat_q(SAT_W'(err_sum)) : '0;
        end
        r_tu <= 42'($signed({r_err, 16'b0})) - 42'(du);
        r_tm <= 42'($signed({r_err, 16'b0})) - 42'(dm);
        r_su <= $signed({1'b0, r_bstep}) * r_tu;
        r_sm <= $signed({1'b0, r_bstep}) * r_tm;

        // movie factor update with old user factor
        r_fa <= r_issue[FEAT_W-1:0] - 1'b1;
        r_a_ep <= r_err * r_p_q;
        r_a_dq <= $signed({1'b0, r_fdecay}) * r_q_q;
        r_a_p <= r_p_q;
        r_a_q <= r_q_q;
        r_fb <= r_fa;
        r_b_t <= 49'(r_a_ep) - 49'(r_a_dq);
        r_b_p <= r_a_p;
        r_b_q <= r_a_q;
        r_fc <= r_fb;
        r_c_s <= $signed({1'b0, r_fstep}) * r_b_t;
        r_c_p <= r_b_p;
        r_c_q <= r_b_q;
        r_fd <= r_fc;
        r_d_q <= q_new;
        r_d_p <= r_c_p;
        // user factor update with new movie factor
        r_fe <= r_fd;
        r_e_eq <= r_err * r_d_q;
        r_e_dp <= $signed({1'b0, r_fdecay}) * r_d_p;
        r_e_p <= r_d_p;
        r_e_q <= r_d_q;
        r_ff <= r_fe;
        r_f_t <= 49'(r_e_eq) - 49'(r_e_dp);
        r_f_p <= r_e_p;
        r_f_q <= r_e_q;
        r_fg <= r_ff;
        r_g_s <= $signed({1'b0, r_fstep}) * r_f_t;
        r_g_p <= r_f_p;
        r_g_q <= r_f_q;
    end

    // memory ports
    always_comb begin
        uf_ra = {r_item.user_index[USER_W-1:0], r_issue[FEAT_W-1:0]};
        mf_ra = {r_item.movie_index[MOVIE_W-1:0], r_issue[FEAT_W-1:0]};
        f_we  = (r_state == S_CLEAR) || r_vg;
        if (r_state == S_CLEAR) begin
            uf_wa = r_clr[UF_AW-1:0];
            mf_wa = r_clr[MF_AW-1:0];
            uf_wd = FACTOR_INIT;
            mf_wd = FACTOR_INIT;
            ub_wa = r_clr[USER_W-1:0];
            mb_wa = r_clr[MOVIE_W-1:0];
            ub_wd = '0;
            mb_wd = '0;
            ub_we = 1'b1;
            mb_we = 1'b1;
        end else begin
            uf_wa = {r_item.user_index[USER_W-1:0], r_fg};
            mf_wa = {r_item.movie_index[MOVIE_W-1:0], r_fg};
            uf_wd = p_new;
            mf_wd = r_g_q;
            ub_wa = r_item.user_index[USER_W-1:0];
            mb_wa = r_item.movie_index[MOVIE_W-1:0];
            ub_wd = (r_state == S_BWRITE) ? sat_q(SAT_W'(su_rnd) + SAT_W'(r_ub_q))
                                          : r_item.load_value;
            mb_wd = (r_state == S_BWRITE) ? sat_q(SAT_W'(sm_rnd) + SAT_W'(r_mb_q))
                                          : r_item.load_value;
            ub_we = (r_state == S_BWRITE)
                 || (r_state == S_ERR && r_item.opcode == OP_LOAD_USER);
            mb_we = (r_state == S_BWRITE)
                 || (r_state == S_ERR && r_item.opcode == OP_LOAD_MOVIE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) r_uf_mem[uf_wa] <= uf_wd;
        r_p_q <= r_uf_mem[uf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) r_mf_mem[mf_wa] <= mf_wd;
        r_q_q <= r_mf_mem[mf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ub_we) r_ub_mem[ub_wa] <= ub_wd;
        r_ub_q <= r_ub_mem[r_item.user_index[USER_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mb_we) r_mb_mem[mb_wa] <= mb_wd;
        r_mb_q <= r_mb_mem[r_item.movie_index[MOVIE_W-1:0]];
    end

endmodule

// File: sv/mfsgd_chk.sv
// port-level checks for the matrix factorization block, bound to the top level
// depends on mfsgd_pkg and matrix_factorization_sgd
module mfsgd_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input mfsgd_pkg::t_item     i_item,
    input logic                 o_valid,
    input mfsgd_pkg::t_result   o_result
);
    import mfsgd_pkg::*;

    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_strobe_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy && $past(busy))
        else $error("result without an item in work");

endmodule

bind matrix_factorization_sgd mfsgd_chk u_mfsgd_chk (.*);

// File: tb/tb_matrix_factorization_sgd.sv
// self-checking testbench for matrix_factorization_sgd: a queue-fed driver and
// a monitor with its own bias / factor predictor; depends on mfsgd_pkg and matrix_factorization_sgd
`timescale 1ns / 1ps
module tb_matrix_factorization_sgd;
    import mfsgd_pkg::*;

    localparam int  HALF_PERIOD = 2;
    localparam int  CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind       kind;
        t_item       item;
        logic [2:0]  idx;
        logic [18:0] data;
        int          gap_pct;
    } t_job;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_item      i_item = '0;
    logic       o_valid;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [18:0] i_cfg_data = '0;

    t_job    jobs[$];
    t_result pending_results[$];
    int      items_sent = 0;
    int      items_taken = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;

    // predictor state
    longint  mean_q, bstep, bdecay, fstep, fdecay, nfeat;
    int      ubias[MAX_USERS];
    int      mbias[MAX_MOVIES];
    int      ufac[MAX_USERS][FEATURES];
    int      mfac[MAX_MOVIES][FEATURES];

    matrix_factorization_sgd u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int clamp_q(longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic longint round_shr(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic int step_bias(int b, int e);
        longint t;
        t = longint'(e) * 65536 - bdecay * longint'(b);
        return clamp_q(longint'(b) + round_shr(bstep * t, 32));
    endfunction

    function automatic int step_factor(int x, int e, int other);
        longint t;
        t = longint'(e) * longint'(other) - fdecay * longint'(x);
        return clamp_q(longint'(x) + round_shr(fstep * t, 32));
    endfunction

    function automatic t_result rate_and_learn(t_item it);
        int      u, m, n, pred, err;
        longint  acc;
        t_result r;
        u = int'(it.user_index) % MAX_USERS;
        m = int'(it.movie_index) % MAX_MOVIES;
        n = (nfeat > FEATURES) ? FEATURES : int'(nfeat);
        acc = 0;
        err = 0;
        for (int f = 0; f < n; f++) acc += longint'(ufac[u][f]) * longint'(mfac[m][f]);
        pred = clamp_q(mean_q + ubias[u] + mbias[m] + round_shr(acc, 16));
        if (it.opcode == OP_TRAIN) begin
            err = clamp_q(longint'(it.rating) * 65536 - pred);
            ubias[u] = step_bias(ubias[u], err);
            mbias[m] = step_bias(mbias[m], err);
            for (int f = 0; f < n; f++) mfac[m][f] = step_factor(mfac[m][f], err, ufac[u][f]);
            for (int f = 0; f < n; f++) ufac[u][f] = step_factor(ufac[u][f], err, mfac[m][f]);
        end else if (it.opcode == OP_LOAD_USER) begin
            ubias[u] = int'(it.load_value);
        end else if (it.opcode == OP_LOAD_MOVIE) begin
            mbias[m] = int'(it.load_value);
        end
        r.prediction = pred[23:0];
        r.error = err[23:0];
        return r;
    endfunction

    // monitor and predictor
    always @(posedge i_clk) begin
        t_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t result expected none actual %h", $time, o_result);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.prediction !== o_result.prediction) begin
                        $display("%0t prediction expected %h actual %h", $time,
                                 want.prediction, o_result.prediction);
                        fail_count++;
                    end
                    if (want.error !== o_result.error) begin
                        $display("%0t error expected %h actual %h", $time,
                                 want.error, o_result.error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                pending_results.push_back(rate_and_learn(i_item));
                items_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GLOBAL_MEAN:  mean_q = i_cfg_data;
                    CFG_BIAS_STEP:    bstep = i_cfg_data[15:0];
                    CFG_BIAS_DECAY:   bdecay = i_cfg_data[15:0];
                    CFG_FACTOR_STEP:  fstep = i_cfg_data[15:0];
                    CFG_FACTOR_DECAY: fdecay = i_cfg_data[15:0];
                    CFG_FEATURES:     nfeat = i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        logic nxt_start, nxt_cfg;
        t_job j;
        nxt_start = start && (items_sent != items_taken);
        nxt_cfg = i_cfg_valid;
        if (i_cfg_valid && o_cfg_ready) nxt_cfg = 1'b0;
        if (i_rst_n && !nxt_start && !nxt_cfg && jobs.size() > 0) begin
            j = jobs[0];
            case (j.kind)
                K_ITEM: begin
                    if ($urandom_range(99) >= j.gap_pct) begin
                        void'(jobs.pop_front());
                        i_item <= j.item;
                        nxt_start = 1'b1;
                        items_sent++;
                    end
                end
                K_CFG: begin
                    if (pending_results.size() == 0 && !busy
                            && items_sent == items_taken) begin
                        void'(jobs.pop_front());
                        i_cfg_index <= j.idx;
                        i_cfg_data <= j.data;
                        nxt_cfg = 1'b1;
                    end
                end
                default: begin
                    if (pending_results.size() == 0 && items_sent == items_taken)
                        void'(jobs.pop_front());
                end
            endcase
        end
        start <= nxt_start;
        i_cfg_valid <= nxt_cfg;
    end

    task automatic add_item(logic [1:0] op, int u, int m, int r, int lv);
        t_job j;
        j.kind = K_ITEM;
        j.item.opcode = op;
        j.item.user_index = u[11:0];
        j.item.movie_index = m[11:0];
        j.item.rating = r[3:0];
        j.item.load_value = lv[23:0];
        j.idx = '0;
        j.data = '0;
        j.gap_pct = idle_pct;
        jobs.push_back(j);
    endtask

    task automatic add_cfg(logic [2:0] idx, int value);
        t_job j;
        j.kind = K_CFG;
        j.item = '0;
        j.idx = idx;
        j.data = value[18:0];
        j.gap_pct = 0;
        jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = K_DRAIN;
        j.item = '0;
        j.idx = '0;
        j.data = '0;
        j.gap_pct = 0;
        jobs.push_back(j);
    endtask

    task automatic add_config(int gm, int bs, int bd, int fs, int fd, int nf);
        add_cfg(CFG_GLOBAL_MEAN, gm);
        add_cfg(CFG_BIAS_STEP, bs);
        add_cfg(CFG_BIAS_DECAY, bd);
        add_cfg(CFG_FACTOR_STEP, fs);
        add_cfg(CFG_FACTOR_DECAY, fd);
        add_cfg(CFG_FEATURES, nf);
    endtask

    task automatic add_random_items(int count);
        int sel, u, m, lv;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                u = $urandom_range(4095);
                m = $urandom_range(4095);
            end else begin
                u = $urandom_range(15);
                m = $urandom_range(15);
            end
            if ($urandom_range(7) == 0) lv = $urandom;
            else lv = $signed($urandom_range(262143)) - 131072;
            if (sel < 60) add_item(OP_TRAIN, u, m, $urandom_range(15), $urandom);
            else if (sel < 80) add_item(OP_PREDICT, u, m, $urandom_range(15), $urandom);
            else if (sel < 90) add_item(OP_LOAD_USER, u, m, $urandom_range(15), lv);
            else add_item(OP_LOAD_MOVIE, u, m, $urandom_range(15), lv);
            if ($urandom_range(99) == 0) add_drain();
        end
    endtask

    initial begin
        int pcts[4];
        pcts = '{0, 77, 0, 17};
        mean_q = 196608; bstep = 328; bdecay = 1311;
        fstep = 328; fdecay = 1311; nfeat = 32;
        for (int i = 0; i < MAX_USERS; i++) begin
            ubias[i] = 0;
            for (int f = 0; f < FEATURES; f++) ufac[i][f] = 13107;
        end
        for (int i = 0; i < MAX_MOVIES; i++) begin
            mbias[i] = 0;
            for (int f = 0; f < FEATURES; f++) mfac[i][f] = 13107;
        end

        // directed items under reset settings
        add_item(OP_PREDICT, 0, 0, 0, 0);
        add_item(OP_TRAIN, 0, 0, 15, 0);
        add_item(OP_TRAIN, 0, 0, 0, 0);
        add_item(OP_LOAD_USER, 0, 4095, 0, 8388607);
        add_item(OP_PREDICT, 0, 4095, 0, 0);
        add_item(OP_TRAIN, 0, 4095, 15, 0);
        add_item(OP_LOAD_USER, 4095, 0, 0, -8388608);
        add_item(OP_LOAD_MOVIE, 4095, 4095, 0, -8388608);
        add_item(OP_PREDICT, 4095, 4095, 0, 0);
        add_item(OP_TRAIN, 4095, 4095, 15, 0);
        add_item(OP_TRAIN, 4095, 4095, 0, 0);
        add_item(OP_LOAD_MOVIE, 2730, 1365, 0, 24'h555555);
        add_item(OP_LOAD_USER, 1365, 2730, 0, 24'haaaaaa);
        add_item(OP_TRAIN, 1365, 1365, 10, 0);
        add_item(OP_PREDICT, 2730, 2730, 5, 0);
        add_item(OP_LOAD_USER, 0, 0, 0, 0);
        add_item(OP_LOAD_MOVIE, 0, 4095, 0, 0);
        add_drain();

        // extremes of the settings
        add_config(327680, 65535, 65535, 65535, 65535, 0);
        add_item(OP_TRAIN, 3, 3, 15, 0);
        add_item(OP_PREDICT, 3, 3, 0, 0);
        add_config(19'h7ffff, 65535, 0, 65535, 0, 1);
        add_item(OP_TRAIN, 3, 3, 0, 0);
        add_item(OP_TRAIN, 3, 3, 15, 0);
        add_config(0, 0, 0, 0, 0, 63);
        add_item(OP_TRAIN, 4, 4, 15, 0);
        add_item(OP_PREDICT, 4, 4, 0, 0);

        for (int p = 0; p < 4; p++) begin
            idle_pct = pcts[p];
            if (p == 0) add_config(196608, 328, 1311, 328, 1311, 32);
            else add_config($urandom_range(327680), $urandom_range(4000),
                            $urandom_range(65535), $urandom_range(4000),
                            $urandom_range(65535), $urandom_range(1, 40));
            add_random_items(170);
            add_drain();
            if (p == 1) add_config(65536, 65535, 65535, 65535, 65535, 5);
            else add_config($urandom_range(327680), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(0, 32));
            add_random_items(100);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (jobs.size() > 0 || items_sent != items_taken
               || pending_results.size() > 0 || i_cfg_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: files.f
sv/mfsgd_pkg.sv
sv/matrix_factorization_sgd.sv
sv/mfsgd_chk.sv
tb/tb_matrix_factorization_sgd.sv
